/* sv/jme_pkg.sv */
// Package for the jackknife mean/error unit: fixed field widths and the
// sequencer state type. No dependencies.
`default_nettype none

package jme_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 11;
    localparam int ROOT_W   = 32;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_MEAN_LD,
        ST_MEAN_DIV,
        ST_MEAN_FIN,
        ST_RD,
        ST_J_LD,
        ST_J_DIV,
        ST_J_FIN,
        ST_SQ_ACC,
        ST_T_MUL,
        ST_T_DIV,
        ST_SQRT_LD,
        ST_SQRT,
        ST_OUT
    } jme_state_t;

endpackage

`default_nettype wire

/* sv/jme_if.sv */
// Valid/ready stream interfaces for the sample input and the result output.
// Depends on jme_pkg for the field widths.
`default_nettype none

interface jme_sample_if;
    import jme_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface jme_result_if;
    import jme_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mean;
    logic        [ROOT_W-1:0]   error;
    logic        [COUNT_W-1:0]  count;
    logic                       overflow;

    modport source (output valid, output mean, output error, output count,
                    output overflow, input ready);
    modport sink (input valid, input mean, input error, input count,
                  input overflow, output ready);
endinterface

`default_nettype wire

/* sv/jme_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
`default_nettype none

module jme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/jackknife_mean_error_unit.sv */
// Jackknife error estimate of the mean of a run of Q16.16 samples.
// Depends on jme_pkg, the stream interfaces in jme_if and jme_ram.
//
//   channel   direction  beat contents                    accepted when
//   samples   in         sample, last                     valid && ready
//   results   out        mean, error, count, overflow     valid && ready
//
// Samples are taken one per cycle while the run is collected. The beat marked
// last starts the closing pass, during which samples.ready is low. That pass
// runs on one shift/subtract divider, one shift/add multiplier and one
// digit-by-digit square root stage, one bit per cycle: first the mean, then
// for each stored sample its leave-one-out mean and the square of its
// deviation from the mean, then the scaling by n-1, the divide by n and the
// root. A run of fewer than two samples goes to the output right after the
// mean. A stalled result holds the block in its output state. Reset is
// asynchronous; no clearing pass is needed because only entries written in
// the current run are read.
`default_nettype none

module jackknife_mean_error_unit #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    jme_sample_if.sink  samples,
    jme_result_if.source results
);
    import jme_pkg::*;

    localparam int LW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = 33 + LW;
    localparam int AW = 2 * SW + 2 + 2 * CW;
    localparam int BW = SW + 1;
    localparam int KW = $clog2(AW + 1);
    localparam int RRW = 33;

    jme_state_t state_reg, state_next;

    logic        [CW-1:0]  cnt_reg;
    logic signed [SW-1:0]  sum_reg;
    logic                  ovf_reg;
    logic        [CW-1:0]  idx_reg;
    logic signed [31:0]    mu_reg;
    logic        [31:0]    err_reg;
    logic        [AW-1:0]  acc_reg;
    logic        [AW-1:0]  q_reg;
    logic        [CW-1:0]  rem_reg;
    logic        [CW-1:0]  dvsr_reg;
    logic                  neg_reg;
    logic        [KW-1:0]  step_reg;
    logic        [AW-1:0]  ma_reg;
    logic        [BW-1:0]  mb_reg;
    logic        [RRW-1:0] sq_rem_reg;
    logic        [31:0]    sq_root_reg;

    logic in_fire, out_fire, store_ok, ram_we;
    logic [31:0] ram_rdata;

    // Divider step.
    logic [CW:0]   div_sh;
    logic          div_ge;
    logic [CW-1:0] div_rem_new;
    logic [AW-1:0] div_q_new;
    // Signed quotient and its 32-bit saturation.
    logic signed [SW:0] qv;
    logic [31:0]        qv_sat;
    // Leave-one-out numerator and deviation.
    logic signed [SW-1:0] num;
    logic [SW-1:0]        num_mag;
    logic [SW-1:0]        sum_mag;
    logic signed [SW+1:0] dv;
    logic [SW+1:0]        dv_mag;
    // Square root step.
    logic [RRW+1:0] sq_sh;
    logic [RRW+1:0] sq_trial;
    logic           sq_ge;

    assign in_fire  = samples.valid && samples.ready;
    assign out_fire = results.valid && results.ready;
    assign store_ok = cnt_reg < CW'(MAX_SAMPLES);

    jme_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[LW-1:0]),
        .wdata (samples.sample),
        .raddr (idx_reg[LW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        div_sh      = {rem_reg, q_reg[AW-1]};
        div_ge      = div_sh >= {1'b0, dvsr_reg};
        div_rem_new = div_ge ? CW'(div_sh - {1'b0, dvsr_reg}) : div_sh[CW-1:0];
        div_q_new   = {q_reg[AW-2:0], div_ge};

        qv = neg_reg ? -$signed({1'b0, q_reg[SW-1:0]}) : $signed({1'b0, q_reg[SW-1:0]});
        if (qv[SW:31] == {(SW-30){1'b0}} || qv[SW:31] == {(SW-30){1'b1}})
        begin
            qv_sat = qv[31:0];
        end
        else
        begin
            qv_sat = qv[SW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end

        sum_mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
        num     = sum_reg - SW'($signed(ram_rdata));
        num_mag = num[SW-1] ? SW'(-num) : SW'(num);

        dv     = {qv[SW], qv} - (SW+2)'(mu_reg);
        dv_mag = dv[SW+1] ? (SW+2)'(-dv) : (SW+2)'(dv);

        sq_sh    = {sq_rem_reg, q_reg[63:62]};
        sq_trial = {1'b0, sq_root_reg, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:  if (in_fire && samples.last) state_next = ST_MEAN_LD;
            ST_MEAN_LD:  state_next = ST_MEAN_DIV;
            ST_MEAN_DIV: if (step_reg == KW'(1)) state_next = ST_MEAN_FIN;
            ST_MEAN_FIN: state_next = (cnt_reg < CW'(2)) ? ST_OUT : ST_RD;
            ST_RD:       state_next = ST_J_LD;
            ST_J_LD:     state_next = ST_J_DIV;
            ST_J_DIV:    if (step_reg == KW'(1)) state_next = ST_J_FIN;
            ST_J_FIN:    state_next = ST_SQ_ACC;
            ST_SQ_ACC:
            begin
                if (mb_reg == '0)
                begin
                    state_next = (idx_reg == cnt_reg - CW'(1)) ? ST_T_MUL : ST_RD;
                end
            end
            ST_T_MUL:    if (mb_reg == '0) state_next = ST_T_DIV;
            ST_T_DIV:    if (step_reg == KW'(1)) state_next = ST_SQRT_LD;
            ST_SQRT_LD:  state_next = (q_reg[AW-1:64] != '0) ? ST_OUT : ST_SQRT;
            ST_SQRT:     if (step_reg == KW'(1)) state_next = ST_OUT;
            ST_OUT:      if (out_fire) state_next = ST_COLLECT;
            default:     state_next = ST_COLLECT;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        samples.ready = (state_reg == ST_COLLECT);
        results.valid = (state_reg == ST_OUT);
        ram_we        = in_fire && store_ok;
    end

    assign results.mean     = mu_reg;
    assign results.error    = err_reg;
    assign results.count    = COUNT_W'(cnt_reg);
    assign results.overflow = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                if (store_ok)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    sum_reg <= sum_reg + SW'(samples.sample);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (out_fire)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    // Datapath of the closing pass; the state register decides which loop
    // the shared divider, multiplier and root stage are serving.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_MEAN_LD:
            begin
                q_reg    <= AW'(sum_mag) << (AW - SW);
                neg_reg  <= sum_reg[SW-1];
                rem_reg  <= '0;
                dvsr_reg <= cnt_reg;
                step_reg <= KW'(SW);
                err_reg  <= '0;
            end
            ST_MEAN_DIV, ST_J_DIV, ST_T_DIV:
            begin
                q_reg    <= div_q_new;
                rem_reg  <= div_rem_new;
                step_reg <= step_reg - KW'(1);
            end
            ST_MEAN_FIN:
            begin
                mu_reg  <= qv_sat;
                idx_reg <= '0;
                acc_reg <= '0;
            end
            ST_J_LD:
            begin
                q_reg    <= AW'(num_mag) << (AW - SW);
                neg_reg  <= num[SW-1];
                rem_reg  <= '0;
                dvsr_reg <= cnt_reg - CW'(1);
                step_reg <= KW'(SW);
            end
            ST_J_FIN:
            begin
                ma_reg <= AW'(dv_mag);
                mb_reg <= dv_mag[BW-1:0];
            end
            ST_SQ_ACC:
            begin
                if (mb_reg != '0)
                begin
                    if (mb_reg[0])
                    begin
                        acc_reg <= acc_reg + ma_reg;
                    end
                    ma_reg <= ma_reg << 1;
                    mb_reg <= mb_reg >> 1;
                end
                else if (idx_reg == cnt_reg - CW'(1))
                begin
                    ma_reg  <= acc_reg;
                    mb_reg  <= BW'(cnt_reg - CW'(1));
                    acc_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            ST_T_MUL:
            begin
                if (mb_reg != '0)
                begin
                    if (mb_reg[0])
                    begin
                        acc_reg <= acc_reg + ma_reg;
                    end
                    ma_reg <= ma_reg << 1;
                    mb_reg <= mb_reg >> 1;
                end
                else
                begin
                    q_reg    <= acc_reg;
                    neg_reg  <= 1'b0;
                    rem_reg  <= '0;
                    dvsr_reg <= cnt_reg;
                    step_reg <= KW'(AW);
                end
            end
            ST_SQRT_LD:
            begin
                err_reg     <= 32'hFFFF_FFFF;
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                step_reg    <= KW'(ROOT_W);
            end
            ST_SQRT:
            begin
                sq_rem_reg  <= sq_ge ? RRW'(sq_sh - sq_trial) : sq_sh[RRW-1:0];
                sq_root_reg <= {sq_root_reg[30:0], sq_ge};
                q_reg       <= q_reg << 2;
                step_reg    <= step_reg - KW'(1);
                if (step_reg == KW'(1))
                begin
                    err_reg <= {sq_root_reg[30:0], sq_ge};
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(samples.ready && results.valid))
        else $error("input taken while a result is pending");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> (cnt_reg == '0) && !ovf_reg && (sum_reg == '0))
        else $error("run state not cleared after result");

    a_small_err: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && cnt_reg < CW'(2)) |-> (results.error == '0))
        else $error("nonzero error with fewer than two samples");
`endif

endmodule

`default_nettype wire

/* verif/jackknife_mean_error_unit_tb.sv */
// Self-checking testbench for jackknife_mean_error_unit: drives runs of
// samples and checks every result beat against a built-in predictor.
// Depends on jme_pkg, the stream interfaces in jme_if and the unit itself.
`timescale 1ns / 100ps

module jackknife_mean_error_unit_tb;
    import jme_pkg::*;

    localparam int    CAPACITY  = 1024;
    localparam int    HOLD_OFF  = 3000;
    localparam int    DRAIN     = 400;
    localparam real   HALF_PER  = 10.0;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } sample_beat_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] mean;
        logic        [ROOT_W-1:0]   error;
        logic        [COUNT_W-1:0]  count;
        logic                       overflow;
    } run_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    jme_sample_if samples ();
    jme_result_if results ();

    jackknife_mean_error_unit #(.MAX_SAMPLES(CAPACITY)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .results (results.source)
    );

    always #(HALF_PER) clk = ~clk;

    // Items waiting to be offered, and the results the predictor expects.
    sample_beat_t pending_beats[$];
    run_result_t  expected_results[$];
    int           total_beats = 0;
    int           total_runs = 0;
    int           sent_beats = 0;
    int           seen_results = 0;
    int           fail_count = 0;

    // Predictor state: the samples stored in the current run, the running
    // sum and whether any sample was dropped because the store was full.
    longint       run_samples[$];
    longint       run_sum = 0;
    bit           run_dropped = 1'b0;

    // The idling pattern depends on how far the stimulus has progressed:
    // first a slow sender with a very slow receiver, then the reverse, then
    // both sides run flat out.
    function automatic int idle_phase();
        if (sent_beats < total_beats / 3)
            return 0;
        else if (sent_beats < (2 * total_beats) / 3)
            return 1;
        return 2;
    endfunction

    // Floor of sqrt(var_sum * (n-1) / n), found bit by bit as the largest e
    // with e*e*n <= var_sum*(n-1).
    function automatic logic [ROOT_W-1:0] jackknife_root(input bit [127:0] var_sum,
                                                         input int n);
        bit [127:0] rhs;
        bit [127:0] trial;
        bit [127:0] root;
        rhs  = var_sum * (n - 1);
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial * n <= rhs)
                root = trial;
        end
        return root[ROOT_W-1:0];
    endfunction

    // Accounts for one accepted sample beat; on the closing beat of a run it
    // queues the expected result and clears the run.
    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] sample,
                                 input logic last);
        longint      mu;
        longint      loo_mean;
        longint      diff;
        bit [127:0]  var_sum;
        bit [127:0]  mag;
        int          n;
        run_result_t res;
        if (run_samples.size() < CAPACITY)
        begin
            run_samples.push_back(longint'(sample));
            run_sum += longint'(sample);
        end
        else
        begin
            run_dropped = 1'b1;
        end
        if (last)
        begin
            n  = run_samples.size();
            mu = run_sum / n;
            if (mu > 64'sd2147483647)
                mu = 64'sd2147483647;
            if (mu < -64'sd2147483648)
                mu = -64'sd2147483648;
            res.mean     = mu[SAMPLE_W-1:0];
            res.error    = '0;
            res.count    = n[COUNT_W-1:0];
            res.overflow = run_dropped;
            if (n >= 2)
            begin
                var_sum = '0;
                foreach (run_samples[i])
                begin
                    // Leave-one-out mean, truncated toward zero like the mean.
                    loo_mean = (run_sum - run_samples[i]) / (n - 1);
                    diff     = loo_mean - mu;
                    mag      = (diff < 0) ? -diff : diff;
                    var_sum += mag * mag;
                end
                res.error = jackknife_root(var_sum, n);
            end
            expected_results.push_back(res);
            run_samples.delete();
            run_sum     = 0;
            run_dropped = 1'b0;
        end
    endtask

    task automatic queue_run(input int length, input int style);
        sample_beat_t beat;
        for (int k = 0; k < length; k++)
        begin
            case (style)
                0: beat.sample = $urandom();
                1: beat.sample = $signed($urandom_range(2000, 0)) - 1000;
                2: beat.sample = $urandom_range(1, 0)
                                 ? 32'sh7FFF_0000 + $urandom_range(65535, 0)
                                 : 32'sh8000_0000 + $urandom_range(65535, 0);
                default: beat.sample = $signed($urandom_range(32'h0008_0000, 0)) - 32'sh0004_0000;
            endcase
            beat.last = (k == length - 1);
            pending_beats.push_back(beat);
        end
    endtask

    task automatic queue_beat(input logic signed [SAMPLE_W-1:0] sample, input logic last);
        sample_beat_t beat;
        beat.sample = sample;
        beat.last   = last;
        pending_beats.push_back(beat);
    endtask

    // Stimulus: a short directed part, then random runs, mostly short, plus
    // one run long enough to overflow the store so that its last beat drops.
    initial
    begin
        // Single-sample runs at the extremes and at zero: the error must be zero.
        queue_beat(32'sh7FFF_FFFF, 1'b1);
        queue_beat(32'sh8000_0000, 1'b1);
        queue_beat(32'sh0000_0000, 1'b1);
        // Two extremes: largest spread, mean truncated toward zero.
        queue_beat(32'sh7FFF_FFFF, 1'b0);
        queue_beat(32'sh8000_0000, 1'b1);
        // All at the positive limit, then all at the negative limit.
        queue_beat(32'sh7FFF_FFFF, 1'b0);
        queue_beat(32'sh7FFF_FFFF, 1'b0);
        queue_beat(32'sh7FFF_FFFF, 1'b1);
        queue_beat(32'sh8000_0000, 1'b0);
        queue_beat(32'sh8000_0000, 1'b0);
        queue_beat(32'sh8000_0000, 1'b1);
        // Small runs with negative samples; the second sum does not divide evenly.
        queue_beat(-32'sd1, 1'b0);
        queue_beat(-32'sd2, 1'b0);
        queue_beat(32'sd0, 1'b1);
        queue_beat(32'sh0001_0000, 1'b0);
        queue_beat(-32'sh0000_8001, 1'b0);
        queue_beat(32'sh0000_0003, 1'b0);
        queue_beat(-32'sd7, 1'b1);
        // Random runs; one overfills the store by a few beats.
        for (int r = 0; r < 80; r++)
        begin
            if (r == 40)
                queue_run(CAPACITY + 6, 0);
            else
                queue_run(($urandom_range(3, 0) == 0) ? $urandom_range(40, 2)
                                                      : $urandom_range(12, 1),
                          $urandom_range(3, 0));
        end
        foreach (pending_beats[k])
        begin
            if (pending_beats[k].last)
                total_runs++;
        end
        total_beats = pending_beats.size();
    end

    // Sample driver: offers the next pending beat unless it idles this cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples.valid  <= 1'b0;
            samples.sample <= '0;
            samples.last   <= 1'b0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                absorb_sample(samples.sample, samples.last);
                sent_beats++;
            end
            if (!samples.valid || samples.ready)
            begin
                if (pending_beats.size() != 0 &&
                    !((idle_phase() == 0 && $urandom_range(99, 0) < 31) ||
                      (idle_phase() == 1 && $urandom_range(99, 0) < 77)))
                begin
                    samples.sample <= pending_beats[0].sample;
                    samples.last   <= pending_beats[0].last;
                    samples.valid  <= 1'b1;
                    void'(pending_beats.pop_front());
                end
                else
                begin
                    samples.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: after the fifth result the receiver stays off until
    // hold_cycles, loaded with HOLD_OFF, counts down to zero while the driver keeps
    // offering, so the unit sits in its output state with its input stalled.
    int hold_cycles = 0;
    int hold_results = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
                hold_results++;
            if (results.valid && results.ready && hold_results == 5)
                hold_cycles <= HOLD_OFF;
            else if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
        end
    end

    // Result monitor with receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat: mean %0d error %0d count %0d",
                           results.mean, results.error, results.count);
                    fail_count++;
                end
                else
                begin
                    if (results.mean !== expected_results[0].mean)
                    begin
                        $error("mean: expected %0d, got %0d",
                               expected_results[0].mean, results.mean);
                        fail_count++;
                    end
                    if (results.error !== expected_results[0].error)
                    begin
                        $error("error: expected %0d, got %0d",
                               expected_results[0].error, results.error);
                        fail_count++;
                    end
                    if (results.count !== expected_results[0].count)
                    begin
                        $error("count: expected %0d, got %0d",
                               expected_results[0].count, results.count);
                        fail_count++;
                    end
                    if (results.overflow !== expected_results[0].overflow)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               expected_results[0].overflow, results.overflow);
                        fail_count++;
                    end
                    void'(expected_results.pop_front());
                end
                seen_results++;
            end
            if (hold_cycles > 0)
            begin
                results.ready <= 1'b0;
            end
            else if (idle_phase() == 0)
            begin
                results.ready <= ($urandom_range(99, 0) >= 77);
            end
            else if (idle_phase() == 1)
            begin
                results.ready <= ($urandom_range(99, 0) >= 31);
            end
            else
            begin
                results.ready <= 1'b1;
            end
        end
    end

    // Reset once, then wait until a result has been seen for every run.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (total_beats != 0);
        @(posedge clk);
        while (seen_results < total_runs)
            @(posedge clk);
        // Allow a stray extra result to show up before the verdict.
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("PASS jackknife_mean_error_unit");
        else
            $display("FAIL jackknife_mean_error_unit");
        $finish;
    end

    // Watchdog, well beyond the slowest correct run.
    initial
    begin
        #(40_000_000);
        $display("FAIL jackknife_mean_error_unit");
        $finish;
    end

endmodule

/* jackknife_mean_error_unit.f */
sv/jme_pkg.sv
sv/jme_if.sv
sv/jme_ram.sv
sv/jackknife_mean_error_unit.sv
verif/jackknife_mean_error_unit_tb.sv
